// File: src/lphi_pkg.sv
// ----------------------------------------------------------------------------
// lphi_pkg
// Shared widths, status codes and controller/datapath interface structs for
// the linear probing hash insert block.
// ----------------------------------------------------------------------------
package lphi_pkg;

  localparam int KEY_W    = 64;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 10;
  localparam int CFG_W    = 4;
  localparam int EPOCH_W  = 8;
  localparam int RAM_W    = KEY_W + EPOCH_W;

  // table_bits limits and reset value
  localparam logic [CFG_W-1:0] TB_MIN   = 4'd1;
  localparam logic [CFG_W-1:0] TB_MAX   = 4'd10;
  localparam logic [CFG_W-1:0] TB_RESET = 4'd10;

  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED = 2'd0,
    ST_ZERO   = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic epoch_step;
    logic clear_init;
    logic clear_write;
    logic place;
    logic emit_zero;
    logic emit_full;
    logic advance;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_key_zero;
    logic in_start_new;
    logic epoch_wrap;
    logic held_key_zero;
    logic clear_last;
    logic slot_empty;
    logic probe_last;
  } ctrl_stat_t;

endpackage

// File: src/lphi_ram.sv
// ----------------------------------------------------------------------------
// lphi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lphi_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/lphi_ctrl.sv
// ----------------------------------------------------------------------------
// lphi_ctrl
// Insert sequencer: boot clear, accept, optional clear pass, probe loop.
// ----------------------------------------------------------------------------
module lphi_ctrl
  import lphi_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd,
  output logic       busy
);

  typedef enum logic [4:0] {
    S_BOOT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CLEAR = 5'b00100,
    S_READ  = 5'b01000,
    S_CHECK = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BOOT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_BOOT: begin
        cmd.clear_write = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (stat.in_start_new && stat.epoch_wrap) begin
            // epoch tags exhausted, sweep the store
            cmd.clear_init = 1'b1;
            state_next     = S_CLEAR;
          end else begin
            cmd.epoch_step = stat.in_start_new;
            if (stat.in_key_zero) begin
              cmd.emit_zero = 1'b1;
            end else begin
              state_next = S_READ;
            end
          end
        end
      end
      S_CLEAR: begin
        cmd.clear_write = 1'b1;
        if (stat.clear_last) begin
          if (stat.held_key_zero) begin
            cmd.emit_zero = 1'b1;
            state_next    = S_IDLE;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.slot_empty) begin
          cmd.place  = 1'b1;
          state_next = S_IDLE;
        end else if (stat.probe_last) begin
          cmd.emit_full = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// File: src/lphi_dp.sv
// ----------------------------------------------------------------------------
// lphi_dp
// Datapath: size register, probe position and count, epoch tag, clear
// sweep counter, slot store and result registers.
// ----------------------------------------------------------------------------
module lphi_dp
  import lphi_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [KEY_W-1:0]    key,
  input  logic                start_new,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  ctrl_cmd_t           cmd,
  output ctrl_stat_t          stat,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot,
  output logic [SLOT_W-1:0]   probes
);

  localparam int AW       = $clog2(TABLE_ENTRIES);
  localparam int MAX_BITS = $clog2(TABLE_ENTRIES + 1) - 1;
  localparam int CAP_BITS = (MAX_BITS < int'(TB_MAX)) ? MAX_BITS : int'(TB_MAX);
  localparam int PW       = CAP_BITS;

  logic [CFG_W-1:0]   table_bits;
  logic [CFG_W-1:0]   eff_bits;
  logic [PW-1:0]      mask_next;
  logic [PW-1:0]      mask;
  logic [PW-1:0]      pos;
  logic [PW-1:0]      probe_cnt;
  logic [KEY_W-1:0]   key_r;
  logic [EPOCH_W-1:0] epoch;
  logic [AW-1:0]      clr;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [RAM_W-1:0]   ram_wdata;
  logic [RAM_W-1:0]   ram_rdata;

  always_comb begin
    eff_bits = table_bits;
    if (eff_bits < TB_MIN) begin
      eff_bits = TB_MIN;
    end
    if (eff_bits > TB_MAX) begin
      eff_bits = TB_MAX;
    end
    if (eff_bits > CFG_W'(CAP_BITS)) begin
      eff_bits = CFG_W'(CAP_BITS);
    end
    mask_next = PW'((32'd1 << eff_bits) - 32'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      table_bits <= TB_RESET;
      epoch      <= '0;
      clr        <= '0;
      done       <= 1'b0;
    end else begin
      if (cfg_we) begin
        table_bits <= cfg_wdata;
      end
      done <= cmd.place | cmd.emit_zero | cmd.emit_full;
      if (cmd.clear_init) begin
        clr <= '0;
      end else if (cmd.clear_write) begin
        clr <= clr + 1'b1;
      end
      if (cmd.clear_init) begin
        epoch <= '0;
      end else if (cmd.epoch_step) begin
        epoch <= epoch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r     <= key;
      mask      <= mask_next;
      pos       <= key[PW-1:0] & mask_next;
      probe_cnt <= '0;
    end else if (cmd.advance) begin
      pos       <= (pos + 1'b1) & mask;
      probe_cnt <= probe_cnt + 1'b1;
    end
    if (cmd.place) begin
      status <= ST_PLACED;
      slot   <= SLOT_W'(pos);
      probes <= SLOT_W'(probe_cnt);
    end else if (cmd.emit_zero) begin
      status <= ST_ZERO;
      slot   <= '0;
      probes <= '0;
    end else if (cmd.emit_full) begin
      status <= ST_FULL;
      slot   <= '0;
      probes <= '0;
    end
  end

  // a slot is empty when its key is zero or its tag is from an older table
  assign ram_we    = cmd.clear_write | cmd.place;
  assign ram_waddr = cmd.clear_write ? clr : AW'(pos);
  assign ram_wdata = cmd.place ? {epoch, key_r} : '0;

  lphi_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (AW'(pos)),
    .rdata (ram_rdata)
  );

  always_comb begin
    stat               = '0;
    stat.in_key_zero   = (key == '0);
    stat.in_start_new  = start_new;
    stat.epoch_wrap    = &epoch;
    stat.held_key_zero = (key_r == '0);
    stat.clear_last    = (clr == AW'(TABLE_ENTRIES - 1));
    stat.slot_empty    = (ram_rdata[KEY_W-1:0] == '0) ||
                         (ram_rdata[RAM_W-1:KEY_W] != epoch);
    stat.probe_last    = (probe_cnt == mask);
  end

endmodule

// File: src/linear_probe_hash_insert_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_insert_core
// Open-addressing hash table builder with linear probing over 64-bit keys.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------
//   input    | start / busy       | key, start_new
//   result   | done (one cycle)   | status, slot, probes
//   config   | cfg_we             | cfg_wdata (table_bits)
//
// an insert probes k+1 slots for k occupied slots skipped; since the store
// has a registered read port, each probe is a read then a check.
// a zero key is answered without probing. after reset a clearing pass over
// all TABLE_ENTRIES slots runs with busy high; the same pass runs on every
// 256th start_new, when the epoch tag wraps, before that key is handled.
// results cannot be stalled; each done beat lands in the cycle after the work.
// ----------------------------------------------------------------------------
module linear_probe_hash_insert_core
  import lphi_pkg::*;
#(
  parameter int TABLE_ENTRIES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [KEY_W-1:0]    key,
  input  logic                start_new,
  input  logic                cfg_we,
  input  logic [CFG_W-1:0]    cfg_wdata,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot,
  output logic [SLOT_W-1:0]   probes
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  lphi_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lphi_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .start_new (start_new),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .status    (status),
    .slot      (slot),
    .probes    (probes)
  );

endmodule
